FILE: hw/rtl/pdfm_pkg.sv
// pdfm_pkg: widths, reset values, microcode encoding and control ROM for the
// PWM duty/frequency meter. No dependencies.
package pdfm_pkg;

    localparam int STAMP_W   = 16;
    localparam int CLK_W     = 24;
    localparam int DVD_W     = 24;
    localparam int CNT_W     = 5;
    localparam int STEP_W    = 3;
    localparam int DUTY_W    = 7;
    localparam int FREQ_W    = 16;

    localparam logic [CLK_W-1:0]  CLK_RESET = 24'd8000000;
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DVD_W - 1);
    localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;
    localparam logic [DUTY_W-1:0] PERCENT   = 7'd100;

    localparam logic [1:0] PH_RISE1 = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_RISE2 = 2'd2;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DDIV  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DSAV  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FDIV  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FSAV  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_CHECK,
        UOP_DIV,
        UOP_SAVE_DUTY,
        UOP_SAVE_FREQ,
        UOP_EMIT,
        UOP_NOP
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_BAD,
        COND_CNT_NZ,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop              uop;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_cword;

    typedef struct packed {
        logic start;
        logic bad;
        logic cnt_nz;
        logic out_busy;
    } t_dp_status;

    function automatic t_cword ucode(input logic [STEP_W-1:0] step);
        t_cword cw;
        unique case (step)
            STEP_IDLE:  cw = '{UOP_WAIT,      COND_NO_START, STEP_IDLE};
            STEP_CHECK: cw = '{UOP_CHECK,     COND_BAD,      STEP_EMIT};
            STEP_DDIV:  cw = '{UOP_DIV,       COND_CNT_NZ,   STEP_DDIV};
            STEP_DSAV:  cw = '{UOP_SAVE_DUTY, COND_NEVER,    STEP_IDLE};
            STEP_FDIV:  cw = '{UOP_DIV,       COND_CNT_NZ,   STEP_FDIV};
            STEP_FSAV:  cw = '{UOP_SAVE_FREQ, COND_NEVER,    STEP_IDLE};
            STEP_EMIT:  cw = '{UOP_EMIT,      COND_OUT_BUSY, STEP_EMIT};
            STEP_DONE:  cw = '{UOP_NOP,       COND_ALWAYS,   STEP_IDLE};
            default:    cw = '{UOP_NOP,       COND_ALWAYS,   STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

FILE: hw/rtl/pdfm_seq.sv
// pdfm_seq: step counter, control ROM lookup and conditional jump logic.
// Depends on pdfm_pkg.
module pdfm_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pdfm_pkg::t_dp_status         i_status,
    output pdfm_pkg::t_cword             o_cword
);

    logic [pdfm_pkg::STEP_W-1:0] r_step;
    logic [pdfm_pkg::STEP_W-1:0] n_step;
    pdfm_pkg::t_cword            cw;
    logic                        take;

    assign cw      = pdfm_pkg::ucode(r_step);
    assign o_cword = cw;

    always_comb begin
        unique case (cw.cond)
            pdfm_pkg::COND_NEVER:    take = 1'b0;
            pdfm_pkg::COND_ALWAYS:   take = 1'b1;
            pdfm_pkg::COND_NO_START: take = !i_status.start;
            pdfm_pkg::COND_BAD:      take = i_status.bad;
            pdfm_pkg::COND_CNT_NZ:   take = i_status.cnt_nz;
            pdfm_pkg::COND_OUT_BUSY: take = i_status.out_busy;
            default:                 take = 1'b1;
        endcase
        n_step = take ? cw.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pdfm_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: hw/rtl/pdfm_dp.sv
// pdfm_dp: stamp capture, phase tracking, shared restoring divider and the
// result register. Driven by control words from pdfm_seq; depends on pdfm_pkg.
module pdfm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pdfm_pkg::t_cword                    i_cword,
    input  logic                                i_in_fire,
    input  logic [pdfm_pkg::STAMP_W-1:0]        i_capture_time,
    input  logic                                i_cfg_we,
    input  logic [pdfm_pkg::CLK_W-1:0]          i_cfg_data,
    input  logic                                i_out_stall,
    output pdfm_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic                                o_in_range,
    output logic [pdfm_pkg::STAMP_W-1:0]        o_high_ticks,
    output logic [pdfm_pkg::STAMP_W-1:0]        o_period_ticks,
    output logic [pdfm_pkg::DUTY_W-1:0]         o_duty_percent,
    output logic [pdfm_pkg::FREQ_W-1:0]         o_frequency_hz,
    output logic                                o_freq_saturated
);

    logic [pdfm_pkg::CLK_W-1:0]   r_clock_hz;
    logic [1:0]                   r_phase;
    logic [pdfm_pkg::STAMP_W-1:0] r_first;
    logic [pdfm_pkg::STAMP_W-1:0] r_fall;
    logic [pdfm_pkg::STAMP_W-1:0] r_high;
    logic [pdfm_pkg::STAMP_W-1:0] r_period;
    logic                         r_ok;
    logic [pdfm_pkg::DVD_W-1:0]   r_dvd;
    logic [pdfm_pkg::STAMP_W-1:0] r_rem;
    logic [pdfm_pkg::CNT_W-1:0]   r_cnt;
    logic [pdfm_pkg::DUTY_W-1:0]  r_duty;
    logic                         r_out_valid;

    logic [pdfm_pkg::STAMP_W:0]   rem_sh;
    logic [pdfm_pkg::STAMP_W:0]   diff;
    logic                         ge;
    logic [pdfm_pkg::DVD_W-1:0]   high_x100;
    logic                         out_free;

    assign rem_sh    = {r_rem, r_dvd[pdfm_pkg::DVD_W-1]};
    assign diff      = rem_sh - {1'b0, r_period};
    assign ge        = !diff[pdfm_pkg::STAMP_W];
    assign high_x100 = ({8'd0, r_high} << 6) + ({8'd0, r_high} << 5)
                     + ({8'd0, r_high} << 2);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_status.start    = i_in_fire && (r_phase == pdfm_pkg::PH_RISE2);
    assign o_status.bad      = !r_ok;
    assign o_status.cnt_nz   = (r_cnt != '0);
    assign o_status.out_busy = !out_free;
    assign o_out_valid       = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= pdfm_pkg::CLK_RESET;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pdfm_pkg::PH_RISE1;
            r_first <= '0;
            r_fall  <= '0;
        end else if (i_in_fire) begin
            if (r_phase == pdfm_pkg::PH_FALL) begin
                r_fall  <= i_capture_time;
                r_phase <= pdfm_pkg::PH_RISE2;
            end else if (r_phase == pdfm_pkg::PH_RISE2) begin
                r_phase <= pdfm_pkg::PH_RISE1;
            end else begin
                r_first <= i_capture_time;
                r_phase <= pdfm_pkg::PH_FALL;
            end
        end
    end

    // third stamp: latch differences and ordering check
    always_ff @(posedge i_clk) begin
        if (o_status.start) begin
            r_high   <= r_fall - r_first;
            r_period <= i_capture_time - r_first;
            r_ok     <= (r_first < r_fall) && (r_fall < i_capture_time);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cword.uop)
            pdfm_pkg::UOP_CHECK: begin
                r_dvd <= high_x100;
                r_rem <= '0;
                r_cnt <= pdfm_pkg::DIV_LAST;
            end
            pdfm_pkg::UOP_DIV: begin
                r_dvd <= {r_dvd[pdfm_pkg::DVD_W-2:0], ge};
                r_rem <= ge ? diff[pdfm_pkg::STAMP_W-1:0] : rem_sh[pdfm_pkg::STAMP_W-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
            pdfm_pkg::UOP_SAVE_DUTY: begin
                r_duty <= r_dvd[pdfm_pkg::DUTY_W-1:0];
                r_dvd  <= r_clock_hz;
                r_rem  <= '0;
                r_cnt  <= pdfm_pkg::DIV_LAST;
            end
            default: begin
            end
        endcase
    end

    // result register; freq is the divider quotient clamped to 16 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cword.uop == pdfm_pkg::UOP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cword.uop == pdfm_pkg::UOP_EMIT && out_free) begin
            o_in_range <= r_ok;
            if (r_ok) begin
                o_high_ticks     <= r_high;
                o_period_ticks   <= r_period;
                o_duty_percent   <= r_duty;
                o_freq_saturated <= |r_dvd[pdfm_pkg::DVD_W-1:pdfm_pkg::FREQ_W];
                o_frequency_hz   <= (|r_dvd[pdfm_pkg::DVD_W-1:pdfm_pkg::FREQ_W])
                                  ? pdfm_pkg::FREQ_MAX : r_dvd[pdfm_pkg::FREQ_W-1:0];
            end else begin
                o_high_ticks     <= '0;
                o_period_ticks   <= '0;
                o_duty_percent   <= '0;
                o_freq_saturated <= 1'b0;
                o_frequency_hz   <= '0;
            end
        end
    end

    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_in_range) |-> (o_high_ticks == '0 && o_period_ticks == '0
            && o_duty_percent == '0 && o_frequency_hz == '0 && !o_freq_saturated))
        else $error("out-of-range beat carries nonzero fields");

    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_freq_saturated) |-> (o_frequency_hz == pdfm_pkg::FREQ_MAX))
        else $error("saturated frequency not clamped");

    a_duty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_in_range) |-> (o_duty_percent < pdfm_pkg::PERCENT
            && o_high_ticks < o_period_ticks))
        else $error("duty or high time out of bounds");

    a_emit_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cword.uop == pdfm_pkg::UOP_EMIT))
        else $error("result raised outside emit step");

endmodule

FILE: hw/rtl/pwm_duty_frequency_meter.sv
// PWM duty/frequency meter. Stamps arrive rising, falling, rising; the third
// stamp starts a microcoded run: one ordering check, a 24-step restoring
// division for duty (high*100/period), a 24-step division for frequency
// (clock_hz/period), then the result beat. After the third stamp of a
// well-ordered triple the input is stalled through the check, two 24-step
// divisions, two save steps, emit and closing step; an out-of-order triple
// skips both divisions and stalls through check, emit and closing step.
// Output back-pressure holds the emit step and lengthens either stall. The
// first two stamps are taken without a stall; the divider is shared by both.
// Depends on pdfm_pkg, pdfm_seq, pdfm_dp.
module pwm_duty_frequency_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pdfm_pkg::CLK_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pdfm_pkg::STAMP_W-1:0]        i_capture_time,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_in_range,
    output logic [pdfm_pkg::STAMP_W-1:0]        o_high_ticks,
    output logic [pdfm_pkg::STAMP_W-1:0]        o_period_ticks,
    output logic [pdfm_pkg::DUTY_W-1:0]         o_duty_percent,
    output logic [pdfm_pkg::FREQ_W-1:0]         o_frequency_hz,
    output logic                                o_freq_saturated
);

    pdfm_pkg::t_cword     cword;
    pdfm_pkg::t_dp_status status;
    logic                 in_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (cword.uop != pdfm_pkg::UOP_WAIT);
    assign in_fire     = i_in_valid && !o_in_stall;

    pdfm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cword  (cword)
    );

    pdfm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cword          (cword),
        .i_in_fire        (in_fire),
        .i_capture_time   (i_capture_time),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_in_range       (o_in_range),
        .o_high_ticks     (o_high_ticks),
        .o_period_ticks   (o_period_ticks),
        .o_duty_percent   (o_duty_percent),
        .o_frequency_hz   (o_frequency_hz),
        .o_freq_saturated (o_freq_saturated)
    );

endmodule
